FILE: sv/sgtm_pkg.sv
`default_nettype none
package sgtm_pkg;
	localparam int MAX_ITEMS   = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(MAX_ITEMS);
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int MATCH_W     = 9;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [1:0] {
		ACT_DEMAND   = 2'd0,
		ACT_CAPACITY = 2'd1,
		ACT_EVAL     = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;   // capture request
		logic ins_start;  // start insertion (pointer = count)
		logic ins_rd;     // read entry pointer-1
		logic ins_shift;  // write read entry at pointer, step down
		logic ins_place;  // write value at pointer, bump count
		logic drop;       // set overflow flag
		logic walk_start;
		logic walk_rd;
		logic walk_step;
		logic out_load;   // capture result, clear lists
	} sgtm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic    full;
		logic    ins_at_bottom;
		logic    ins_gt;
		logic    walk_done;
		action_t action;
	} sgtm_stat_t;
endpackage
`default_nettype wire

FILE: sv/sgtm_if.sv
`default_nettype none
interface sgtm_req_if;
	import sgtm_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] amount;
	modport source(output valid, action, amount, input ready);
	modport sink(input valid, action, amount, output ready);
endinterface

interface sgtm_res_if;
	logic       valid;
	logic       ready;
	logic [8:0] matches_res;
	logic       overflowed;
	modport source(output valid, matches_res, overflowed, input ready);
	modport sink(input valid, matches_res, overflowed, output ready);
endinterface
`default_nettype wire

FILE: sv/sgtm_datapath.sv
`default_nettype none
module sgtm_datapath
	import sgtm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sgtm_cmd_t  cmd,
	output sgtm_stat_t      stat,
	input  wire logic [1:0] in_action,
	input  wire logic [31:0] in_amount,
	output logic [MATCH_W-1:0] res_matches,
	output logic            res_overflow
);
	value_t dem_mem [MAX_ITEMS];
	value_t cap_mem [MAX_ITEMS];

	action_t act_q;
	value_t  val_q;
	cnt_t    dcnt_q, ccnt_q, ptr_q, dptr_q, cptr_q;
	logic    drop_q;
	logic [MATCH_W-1:0] hits_q;
	value_t  drd_q, crd_q;
	value_t  cur_q;

	logic  is_dem;
	cnt_t  cnt;
	idx_t  rd_idx, wr_idx;

	assign is_dem = (act_q == ACT_DEMAND);
	assign cnt    = is_dem ? dcnt_q : ccnt_q;
	assign rd_idx = idx_t'(ptr_q - cnt_t'(1));
	assign wr_idx = ptr_q[IDX_W-1:0];

	// demand store: one write, one read port
	always_ff @(posedge clk) begin
		if (is_dem && (cmd.ins_shift || cmd.ins_place))
			dem_mem[wr_idx] <= cmd.ins_shift ? cur_q : val_q;
		if (cmd.ins_rd)
			drd_q <= dem_mem[rd_idx];
		else if (cmd.walk_rd)
			drd_q <= dem_mem[idx_t'(dptr_q - cnt_t'(1))];
	end

	always_ff @(posedge clk) begin
		if (!is_dem && (cmd.ins_shift || cmd.ins_place))
			cap_mem[wr_idx] <= cmd.ins_shift ? cur_q : val_q;
		if (cmd.ins_rd)
			crd_q <= cap_mem[rd_idx];
		else if (cmd.walk_rd)
			crd_q <= cap_mem[idx_t'(cptr_q - cnt_t'(1))];
	end

	always_comb begin
		cur_q = is_dem ? drd_q : crd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q <= action_t'(in_action);
			val_q <= in_amount[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			ccnt_q <= '0;
			drop_q <= 1'b0;
			ptr_q  <= '0;
			dptr_q <= '0;
			cptr_q <= '0;
			hits_q <= '0;
			res_matches  <= '0;
			res_overflow <= 1'b0;
		end else begin
			if (cmd.ins_start)
				ptr_q <= cnt;
			if (cmd.ins_shift)
				ptr_q <= ptr_q - cnt_t'(1);
			if (cmd.ins_place) begin
				if (is_dem) dcnt_q <= dcnt_q + cnt_t'(1);
				else        ccnt_q <= ccnt_q + cnt_t'(1);
			end
			if (cmd.drop)
				drop_q <= 1'b1;
			if (cmd.walk_start) begin
				dptr_q <= dcnt_q;
				cptr_q <= ccnt_q;
				hits_q <= '0;
			end
			if (cmd.walk_step) begin
				dptr_q <= dptr_q - cnt_t'(1);
				if (drd_q <= crd_q) begin
					cptr_q <= cptr_q - cnt_t'(1);
					hits_q <= hits_q + MATCH_W'(1);
				end
			end
			if (cmd.out_load) begin
				res_matches  <= hits_q;
				res_overflow <= drop_q;
				dcnt_q <= '0;
				ccnt_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	assign stat.action        = act_q;
	assign stat.full          = (cnt == cnt_t'(MAX_ITEMS));
	assign stat.ins_at_bottom = (ptr_q == '0);
	assign stat.ins_gt        = (cur_q > val_q);
	assign stat.walk_done     = (dptr_q == '0) || (cptr_q == '0);
endmodule
`default_nettype wire

FILE: sv/sgtm_ctrl.sv
`default_nettype none
module sgtm_ctrl
	import sgtm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sgtm_stat_t stat,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output sgtm_cmd_t       cmd
);
	state_t state_q, state_d;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		ov_d     = ov_q;
		in_ready = 1'b0;
		if (ov_q && out_ready)
			ov_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = ST_INS_RD;
				end
			end
			ST_INS_RD: begin
				case (stat.action)
					ACT_DEMAND, ACT_CAPACITY: begin
						if (stat.full) begin
							cmd.drop = 1'b1;
							state_d  = ST_IDLE;
						end else begin
							cmd.ins_start = 1'b1;
							state_d = ST_INS_CMP;
						end
					end
					ACT_EVAL: begin
						cmd.walk_start = 1'b1;
						state_d = ST_WALK_RD;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_INS_CMP: begin
				// pointer valid; read below it, then decide next cycle
				if (stat.ins_at_bottom) begin
					cmd.ins_place = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// compare entry below pointer with new value
				if (stat.ins_gt) begin
					cmd.ins_shift = 1'b1;
					state_d = ST_INS_CMP;
				end else begin
					cmd.ins_place = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WALK_RD: begin
				if (stat.walk_done) begin
					if (!ov_q || out_ready) begin
						cmd.out_load = 1'b1;
						ov_d = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.walk_rd = 1'b1;
					state_d = ST_WALK_CMP;
				end
			end
			ST_WALK_CMP: begin
				cmd.walk_step = 1'b1;
				state_d = ST_WALK_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

FILE: sv/sorted_greedy_threshold_matching.sv
`default_nettype none
// Greedy demand/capacity matcher.
// Request channel (req): action 0 appends amount to the demand list,
// 1 to the capacity list, 2 evaluates; 3 is ignored. Both lists are kept
// ascending by insertion sort in on-chip RAM.
// Result channel (res): one result per evaluate: matches_res and
// overflowed (a value was dropped on a full list since the last evaluate).
// Evaluate clears both lists and the flag.
// Timing: a request is taken from idle. An append reads each entry above the
// new value and writes it one place up, then writes the new value; a
// full-list drop or ignored request returns straight to idle. Evaluate
// walks the demand list from the top and stops when either list is exhausted.
// The result sits in an output register; appends continue while it waits.
// A second evaluate stalls until the pending result is taken.
// Reset clears counts, flag and the output valid; RAM contents are not
// cleared and need no clearing pass.
module sorted_greedy_threshold_matching
	import sgtm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sgtm_req_if.sink   req,
	sgtm_res_if.source res
);
	sgtm_cmd_t  cmd;
	sgtm_stat_t stat;

	sgtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	sgtm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_action    (req.action),
		.in_amount    (req.amount),
		.res_matches  (res.matches_res),
		.res_overflow (res.overflowed)
	);
endmodule
`default_nettype wire

FILE: test/sorted_greedy_threshold_matching_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module sorted_greedy_threshold_matching_tb;
	import sgtm_pkg::*;

	logic clk;
	logic arst_n;
	sgtm_req_if req();
	sgtm_res_if res();

	sorted_greedy_threshold_matching DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.res(res.source)
	);

	typedef struct packed {
		logic [8:0] matches_res;
		logic       overflowed;
	} match_t;

	typedef struct {
		action_t    act;
		logic [31:0] amount;
		logic       typed;
		match_t     want;
	} row_t;

	// predictor state
	value_t demand_list[$];
	value_t capacity_list[$];
	logic   dropped;
	match_t pending_matches[$];

	int mismatches = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int recv_hold = 0;
	localparam int LIMIT = 4000000;

	task automatic sorted_add(ref value_t lst[$], input value_t v);
		int pos;
		if (lst.size() >= MAX_ITEMS) begin
			dropped = 1'b1;
			return;
		end
		pos = lst.size();
		while (pos > 0 && lst[pos-1] > v) pos--;
		lst.insert(pos, v);
	endtask

	function automatic match_t count_matches();
		match_t r;
		int di;
		int ci;
		int hits;
		di = demand_list.size();
		ci = capacity_list.size();
		hits = 0;
		while (di > 0 && ci > 0) begin
			if (demand_list[di-1] <= capacity_list[ci-1]) begin
				ci--;
				hits++;
			end
			di--;
		end
		r.matches_res = hits[8:0];
		r.overflowed = dropped;
		return r;
	endfunction

	task automatic predict(input action_t a, input logic [31:0] v);
		case (a)
			ACT_DEMAND: sorted_add(demand_list, v);
			ACT_CAPACITY: sorted_add(capacity_list, v);
			ACT_EVAL: begin
				pending_matches.push_back(count_matches());
				demand_list.delete();
				capacity_list.delete();
				dropped = 1'b0;
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (pending_matches.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d/%0b", res.matches_res, res.overflowed);
				end else begin
					match_t w;
					w = pending_matches.pop_front();
					if (w.matches_res !== res.matches_res || w.overflowed !== res.overflowed) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %0d/%0b got %0d/%0b", w.matches_res,
								w.overflowed, res.matches_res, res.overflowed);
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	row_t rows[$];

	task automatic add_row(input action_t a, input logic [31:0] v, input logic t,
			input logic [8:0] m, input logic o);
		row_t r;
		r.act = a;
		r.amount = v;
		r.typed = t;
		r.want = '{m, o};
		rows.push_back(r);
	endtask

	// leave valid high after the accepting edge; the next send or drain sets it
	task automatic send(input action_t a, input logic [31:0] v);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= a;
		req.amount <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict(a, v);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	action_t a;
	logic [31:0] v;
	int n;
	int k;
	int len;

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_NONE;
		req.amount = '0;
		dropped = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		add_row(ACT_EVAL, 32'h0, 1, 9'd0, 0);
		add_row(ACT_DEMAND, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(ACT_CAPACITY, 32'h0, 0, 0, 0);
		add_row(ACT_EVAL, 32'hFFFF_FFFF, 1, 9'd0, 0);
		add_row(ACT_DEMAND, 32'h0, 0, 0, 0);
		add_row(ACT_CAPACITY, 32'h0, 0, 0, 0);
		add_row(ACT_NONE, 32'h1234_5678, 0, 0, 0);
		add_row(ACT_EVAL, 32'h0, 1, 9'd1, 0);
		add_row(ACT_DEMAND, 32'h5, 0, 0, 0);
		add_row(ACT_DEMAND, 32'h3, 0, 0, 0);
		add_row(ACT_DEMAND, 32'h9, 0, 0, 0);
		add_row(ACT_CAPACITY, 32'h4, 0, 0, 0);
		add_row(ACT_CAPACITY, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(ACT_EVAL, 32'h0, 0, 0, 0);
		add_row(ACT_CAPACITY, 32'hAAAA_5555, 0, 0, 0);
		add_row(ACT_EVAL, 32'h5555_AAAA, 1, 9'd0, 0);
		foreach (rows[i]) begin
			send(rows[i].act, rows[i].amount);
			if (rows[i].typed && rows[i].act == ACT_EVAL) begin
				// replace the predicted entry with the typed one
				void'(pending_matches.pop_back());
				pending_matches.push_back(rows[i].want);
			end
		end
		drain();

		// fill the demand list past full: overflow and a walk over a full demand list
		for (k = 0; k < MAX_ITEMS + 2; k++) send(ACT_DEMAND, $urandom);
		for (k = 0; k < 30; k++) send(ACT_CAPACITY, $urandom);
		send(ACT_EVAL, 0);
		drain();

		// receiver holds off while evaluates back up the input
		recv_hold = 300;
		for (k = 0; k < 6; k++) begin
			send(ACT_DEMAND, $urandom_range(20));
			send(ACT_CAPACITY, $urandom_range(20));
			send(ACT_EVAL, $urandom);
		end
		drain();

		for (n = 0; n < 4; n++) begin
			case (n)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 66; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 66; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			for (k = 0; k < 16; k++) begin
				if ($urandom_range(9) == 0) begin
					a = action_t'($urandom_range(3));
					send(a, $urandom);
				end else if ($urandom_range(5) == 0) begin
					send(ACT_EVAL, $urandom);
				end else begin
					a = $urandom_range(1) ? ACT_CAPACITY : ACT_DEMAND;
					len = $urandom_range(3);
					v = $urandom;
					if (len == 0) v = v & 32'hF;
					else if (len == 1) v = v | 32'hFFFF_FFF0;
					send(a, v);
				end
			end
			send(ACT_EVAL, 0);
			drain();
		end
		drain();

		if (mismatches == 0 && pending_matches.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
